### rtl/core/xtrg_pkg.sv
// ----------------------------------------------------------------------------
// xtrg_pkg: shared types and constants of the XYZ to RGB pixel converter
// Field widths, fixed-point formats, the conversion matrix and the gamma
// threshold table that is built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package xtrg_pkg;

   // configurable precision
   localparam int GAMMA_LUT_BITS  = 10;
   localparam int INPUT_FRAC_BITS = 12;

   // field widths
   localparam int XYZ_W   = 24;
   localparam int COORD_W = 12;
   localparam int CHAN_W  = 8;
   localparam int INV_W   = 17;
   localparam int NUM_CH  = 3;

   localparam logic [INV_W-1:0] INV_RESET = INV_W'(1 << 16);

   // fixed-point formats
   localparam int COEF_W     = 16;
   localparam int COEF_FRAC  = 13;
   localparam int SCALE_FRAC = 16;
   localparam int PROD_W     = XYZ_W + COEF_W + 1;
   localparam int ACC_W      = PROD_W + 2;
   localparam int MAG_W      = ACC_W - 1;
   localparam int LO_W       = XYZ_W;
   localparam int HI_W       = MAG_W - LO_W;
   localparam int VAL_W      = MAG_W + INV_W;
   localparam int VAL_FRAC   = INPUT_FRAC_BITS + COEF_FRAC + SCALE_FRAC;
   localparam int IDX_SHIFT  = VAL_FRAC - GAMMA_LUT_BITS;

   // gamma table geometry
   localparam int LUT_N        = 1 << GAMMA_LUT_BITS;
   localparam int LUT_IDX_W    = GAMMA_LUT_BITS + 1;
   localparam int LUT_LEVELS   = 1 << CHAN_W;
   localparam int SEARCH_STEPS = CHAN_W;
   localparam int BIG_W        = 192;

   // xyz to linear rgb, signed q3.13
   localparam logic signed [COEF_W-1:0] MAT [NUM_CH][NUM_CH] = '{
      '{ 16'sd26546, -16'sd12592, -16'sd4084},
      '{-16'sd7940,   16'sd15368,  16'sd340 },
      '{ 16'sd456,   -16'sd1672,   16'sd8661}
   };

   typedef struct packed {
      logic [XYZ_W-1:0]   x_sum;
      logic [XYZ_W-1:0]   y_sum;
      logic [XYZ_W-1:0]   z_sum;
      logic [COORD_W-1:0] pixel_col;
      logic [COORD_W-1:0] pixel_row;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_col;
      logic [COORD_W-1:0] out_row;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
   } rsp_type;

   // valid bit and pixel coordinates that ride along each pipeline stage
   typedef struct packed {
      logic               valid;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } pipe_tag_type;

   typedef logic [XYZ_W-1:0]        xyz_vec_type [NUM_CH];
   typedef logic signed [ACC_W-1:0] acc_vec_type [NUM_CH];
   typedef logic [LUT_IDX_W-1:0]    idx_vec_type [NUM_CH];
   typedef logic [CHAN_W-1:0]       chan_vec_type [NUM_CH];
   typedef logic [LUT_IDX_W-1:0]    thr_table_type [LUT_LEVELS];

   function automatic logic [BIG_W-1:0] big_pow(input logic [BIG_W-1:0] base,
                                                input int expo);
      logic [BIG_W-1:0] r;
      int               k;
      r = BIG_W'(1);
      for (k = 0; k < expo; k++) begin
         r = r * base;
      end
      return r;
   endfunction

   // smallest index whose gamma output reaches level v:
   // idx^5 * 510^11 >= (2v-1)^11 * N^5
   function automatic logic [LUT_IDX_W-1:0] thr_of(input int v);
      logic [BIG_W-1:0] rhs;
      logic [BIG_W-1:0] lhs;
      logic [BIG_W-1:0] p510;
      int               lo;
      int               hi;
      int               mid;
      int               i;
      lo = 0;
      hi = LUT_N;
      if (v > 0) begin
         p510 = big_pow(BIG_W'(510), 11);
         rhs  = big_pow(BIG_W'(2 * v - 1), 11) * big_pow(BIG_W'(LUT_N), 5);
         for (i = 0; i < LUT_IDX_W + 1; i++) begin
            if (lo < hi) begin
               mid = (lo + hi) >> 1;
               lhs = big_pow(BIG_W'(mid), 5) * p510;
               if (lhs >= rhs) begin
                  hi = mid;
               end else begin
                  lo = mid + 1;
               end
            end
         end
      end
      return LUT_IDX_W'(lo);
   endfunction

   function automatic thr_table_type build_thresh();
      thr_table_type t;
      int            v;
      for (v = 0; v < LUT_LEVELS; v++) begin
         t[v] = thr_of(v);
      end
      return t;
   endfunction

   localparam thr_table_type GAMMA_THR = build_thresh();

endpackage

`default_nettype wire

### rtl/core/xtrg_matrix.sv
// ----------------------------------------------------------------------------
// xtrg_matrix: 3x3 color matrix
// Stage one forms the nine coefficient products, stage two sums each row.
// ----------------------------------------------------------------------------
`default_nettype none

module xtrg_matrix (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire xtrg_pkg::pipe_tag_type tag_in,
   input  wire xtrg_pkg::xyz_vec_type  xyz_in,
   output xtrg_pkg::pipe_tag_type      tag_out,
   output xtrg_pkg::acc_vec_type       acc_out
);

   logic signed [xtrg_pkg::PROD_W-1:0] prod_in [xtrg_pkg::NUM_CH][xtrg_pkg::NUM_CH];
   logic signed [xtrg_pkg::PROD_W-1:0] prod_ff [xtrg_pkg::NUM_CH][xtrg_pkg::NUM_CH];
   xtrg_pkg::acc_vec_type              acc_in;
   xtrg_pkg::acc_vec_type              acc_ff;
   xtrg_pkg::pipe_tag_type             tag1_ff;
   xtrg_pkg::pipe_tag_type             tag2_ff;

   always_comb begin
      for (int c = 0; c < xtrg_pkg::NUM_CH; c++) begin
         for (int k = 0; k < xtrg_pkg::NUM_CH; k++) begin
            prod_in[c][k] = xtrg_pkg::PROD_W'($signed({1'b0, xyz_in[k]})
                                              * xtrg_pkg::MAT[c][k]);
         end
      end
   end

   always_comb begin
      for (int c = 0; c < xtrg_pkg::NUM_CH; c++) begin
         acc_in[c] = xtrg_pkg::ACC_W'(prod_ff[c][0]) + xtrg_pkg::ACC_W'(prod_ff[c][1])
                   + xtrg_pkg::ACC_W'(prod_ff[c][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
      end else if (en) begin
         tag1_ff.valid <= tag_in.valid;
         tag2_ff.valid <= tag1_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff     <= prod_in;
         acc_ff      <= acc_in;
         tag1_ff.col <= tag_in.col;
         tag1_ff.row <= tag_in.row;
         tag2_ff.col <= tag1_ff.col;
         tag2_ff.row <= tag1_ff.row;
      end
   end

   assign tag_out = tag2_ff;
   assign acc_out = acc_ff;

endmodule

`default_nettype wire

### rtl/core/xtrg_scale.sv
// ----------------------------------------------------------------------------
// xtrg_scale: sample scaling and table index
// Clamps negative sums to zero, multiplies by the reciprocal sample count in
// two partial products, saturates at one and rounds to the gamma grid.
// ----------------------------------------------------------------------------
`default_nettype none

module xtrg_scale (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic [xtrg_pkg::INV_W-1:0] inv_samples,
   input  wire xtrg_pkg::pipe_tag_type     tag_in,
   input  wire xtrg_pkg::acc_vec_type      acc_in,
   output xtrg_pkg::pipe_tag_type          tag_out,
   output xtrg_pkg::idx_vec_type           idx_out
);

   localparam int LO_P_W = xtrg_pkg::LO_W + xtrg_pkg::INV_W;
   localparam int HI_P_W = xtrg_pkg::HI_W + xtrg_pkg::INV_W;
   localparam int SAT_W  = xtrg_pkg::VAL_FRAC + 1;
   localparam logic [xtrg_pkg::VAL_W-1:0] CAP  = xtrg_pkg::VAL_W'(1) << xtrg_pkg::VAL_FRAC;
   localparam logic [SAT_W-1:0]           HALF = SAT_W'(1) << (xtrg_pkg::IDX_SHIFT - 1);

   logic [xtrg_pkg::MAG_W-1:0] mag      [xtrg_pkg::NUM_CH];
   logic [LO_P_W-1:0]          lo_in    [xtrg_pkg::NUM_CH];
   logic [LO_P_W-1:0]          lo_ff    [xtrg_pkg::NUM_CH];
   logic [HI_P_W-1:0]          hi_in    [xtrg_pkg::NUM_CH];
   logic [HI_P_W-1:0]          hi_ff    [xtrg_pkg::NUM_CH];
   logic [xtrg_pkg::VAL_W-1:0] val_in   [xtrg_pkg::NUM_CH];
   logic [xtrg_pkg::VAL_W-1:0] val_ff   [xtrg_pkg::NUM_CH];
   logic [SAT_W-1:0]           sat      [xtrg_pkg::NUM_CH];
   logic [SAT_W-1:0]           rnd      [xtrg_pkg::NUM_CH];
   xtrg_pkg::idx_vec_type      idx_in;
   xtrg_pkg::idx_vec_type      idx_ff;
   xtrg_pkg::pipe_tag_type     tag3_ff;
   xtrg_pkg::pipe_tag_type     tag4_ff;
   xtrg_pkg::pipe_tag_type     tag5_ff;

   always_comb begin
      for (int c = 0; c < xtrg_pkg::NUM_CH; c++) begin
         // zero or negative sums give black
         mag[c]   = acc_in[c][xtrg_pkg::ACC_W-1] ? '0 : acc_in[c][xtrg_pkg::MAG_W-1:0];
         lo_in[c] = LO_P_W'(mag[c][xtrg_pkg::LO_W-1:0]) * LO_P_W'(inv_samples);
         hi_in[c] = HI_P_W'(mag[c][xtrg_pkg::MAG_W-1:xtrg_pkg::LO_W]) * HI_P_W'(inv_samples);
      end
   end

   always_comb begin
      for (int c = 0; c < xtrg_pkg::NUM_CH; c++) begin
         val_in[c] = {hi_ff[c], {xtrg_pkg::LO_W{1'b0}}} + xtrg_pkg::VAL_W'(lo_ff[c]);
      end
   end

   always_comb begin
      for (int c = 0; c < xtrg_pkg::NUM_CH; c++) begin
         sat[c]    = (val_ff[c] > CAP) ? CAP[SAT_W-1:0] : val_ff[c][SAT_W-1:0];
         rnd[c]    = sat[c] + HALF;
         idx_in[c] = rnd[c][SAT_W-1:xtrg_pkg::IDX_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag3_ff.valid <= 1'b0;
         tag4_ff.valid <= 1'b0;
         tag5_ff.valid <= 1'b0;
      end else if (en) begin
         tag3_ff.valid <= tag_in.valid;
         tag4_ff.valid <= tag3_ff.valid;
         tag5_ff.valid <= tag4_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
         val_ff      <= val_in;
         idx_ff      <= idx_in;
         tag3_ff.col <= tag_in.col;
         tag3_ff.row <= tag_in.row;
         tag4_ff.col <= tag3_ff.col;
         tag4_ff.row <= tag3_ff.row;
         tag5_ff.col <= tag4_ff.col;
         tag5_ff.row <= tag4_ff.row;
      end
   end

   assign tag_out = tag5_ff;
   assign idx_out = idx_ff;

endmodule

`default_nettype wire

### rtl/core/xtrg_gamma.sv
// ----------------------------------------------------------------------------
// xtrg_gamma: gamma 1/2.2 lookup
// Binary search over the level thresholds, one output bit per stage, msb
// first. A level is kept when its threshold does not exceed the index.
// ----------------------------------------------------------------------------
`default_nettype none

module xtrg_gamma (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire xtrg_pkg::pipe_tag_type tag_in,
   input  wire xtrg_pkg::idx_vec_type  idx_in,
   output xtrg_pkg::pipe_tag_type      tag_out,
   output xtrg_pkg::chan_vec_type      lvl_out
);

   localparam int STEPS = xtrg_pkg::SEARCH_STEPS;

   xtrg_pkg::pipe_tag_type             tag_ff [STEPS];
   logic [xtrg_pkg::CHAN_W-1:0]        lvl_ff [STEPS][xtrg_pkg::NUM_CH];
   logic [xtrg_pkg::LUT_IDX_W-1:0]     idx_ff [STEPS][xtrg_pkg::NUM_CH];

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      localparam logic [xtrg_pkg::CHAN_W-1:0] BIT_MASK =
         xtrg_pkg::CHAN_W'(1) << (STEPS - 1 - s);

      xtrg_pkg::pipe_tag_type         tag_prev;
      logic [xtrg_pkg::CHAN_W-1:0]    lvl_prev [xtrg_pkg::NUM_CH];
      logic [xtrg_pkg::LUT_IDX_W-1:0] idx_prev [xtrg_pkg::NUM_CH];
      logic [xtrg_pkg::CHAN_W-1:0]    cand     [xtrg_pkg::NUM_CH];
      logic [xtrg_pkg::CHAN_W-1:0]    lvl_in   [xtrg_pkg::NUM_CH];

      if (s == 0) begin : g_first
         assign tag_prev = tag_in;
         always_comb begin
            for (int c = 0; c < xtrg_pkg::NUM_CH; c++) begin
               lvl_prev[c] = '0;
               idx_prev[c] = idx_in[c];
            end
         end
      end else begin : g_next
         assign tag_prev = tag_ff[s-1];
         always_comb begin
            for (int c = 0; c < xtrg_pkg::NUM_CH; c++) begin
               lvl_prev[c] = lvl_ff[s-1][c];
               idx_prev[c] = idx_ff[s-1][c];
            end
         end
      end

      always_comb begin
         for (int c = 0; c < xtrg_pkg::NUM_CH; c++) begin
            cand[c]   = lvl_prev[c] | BIT_MASK;
            lvl_in[c] = (xtrg_pkg::GAMMA_THR[cand[c]] <= idx_prev[c]) ? cand[c]
                                                                      : lvl_prev[c];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[s].valid <= 1'b0;
         end else if (en) begin
            tag_ff[s].valid <= tag_prev.valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[s].col <= tag_prev.col;
            tag_ff[s].row <= tag_prev.row;
            lvl_ff[s]     <= lvl_in;
            idx_ff[s]     <= idx_prev;
         end
      end
   end

   assign tag_out = tag_ff[STEPS-1];
   assign lvl_out = lvl_ff[STEPS-1];

endmodule

`default_nettype wire

### rtl/core/xyz_to_rgb_gamma_pixel.sv
// ----------------------------------------------------------------------------
// xyz_to_rgb_gamma_pixel: accumulated CIE XYZ pixel to 8-bit gamma RGB
// Matrix, sample scaling, clamp, gamma 1/2.2 and output register.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock while req_stall is low and returns one
// result per request, in order: two stages of color matrix, three of scaling
// and rounding to the gamma grid, eight of threshold search (one per output
// bit) and the output register. The whole pipeline advances together and
// holds while a result waits under rsp_stall, so req_stall follows it.
// csr_wr_data carries inv_samples, unsigned q1.16 (reset 1.0), and should only
// be written while no request is in flight.
`default_nettype none

module xyz_to_rgb_gamma_pixel (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire xtrg_pkg::req_type          req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output xtrg_pkg::rsp_type               rsp_data,
   input  wire logic                       csr_wr_en,
   input  wire logic [xtrg_pkg::INV_W-1:0] csr_wr_data
);

   logic                          en;
   logic [xtrg_pkg::INV_W-1:0]    inv_samples_ff;
   xtrg_pkg::pipe_tag_type        tag_req;
   xtrg_pkg::xyz_vec_type         xyz;
   xtrg_pkg::pipe_tag_type        tag_mat;
   xtrg_pkg::acc_vec_type         acc;
   xtrg_pkg::pipe_tag_type        tag_scl;
   xtrg_pkg::idx_vec_type         idx;
   xtrg_pkg::pipe_tag_type        tag_gam;
   xtrg_pkg::chan_vec_type        lvl;
   logic                          rsp_valid_ff;
   xtrg_pkg::rsp_type             rsp_data_in;
   xtrg_pkg::rsp_type             rsp_data_ff;

   // everything moves unless a finished result is being held
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   assign tag_req.valid = req_valid;
   assign tag_req.col   = req_data.pixel_col;
   assign tag_req.row   = req_data.pixel_row;
   assign xyz[0]        = req_data.x_sum;
   assign xyz[1]        = req_data.y_sum;
   assign xyz[2]        = req_data.z_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_samples_ff <= xtrg_pkg::INV_RESET;
      end else if (csr_wr_en) begin
         inv_samples_ff <= csr_wr_data;
      end
   end

   xtrg_matrix u_matrix (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .tag_in  (tag_req),
      .xyz_in  (xyz),
      .tag_out (tag_mat),
      .acc_out (acc)
   );

   xtrg_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .inv_samples (inv_samples_ff),
      .tag_in      (tag_mat),
      .acc_in      (acc),
      .tag_out     (tag_scl),
      .idx_out     (idx)
   );

   xtrg_gamma u_gamma (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .tag_in  (tag_scl),
      .idx_in  (idx),
      .tag_out (tag_gam),
      .lvl_out (lvl)
   );

   always_comb begin
      rsp_data_in.out_col = tag_gam.col;
      rsp_data_in.out_row = tag_gam.row;
      rsp_data_in.red     = lvl[0];
      rsp_data_in.green   = lvl[1];
      rsp_data_in.blue    = lvl[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= tag_gam.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
